>>> hdl/nra_pkg.sv
// ----------------------------------------------------------------------------
// nra_pkg
// Shared constants for the name range allocator: defaults, opcodes, status.
// ----------------------------------------------------------------------------
package nra_pkg;

  localparam int DEF_MAX_INTERVALS = 16;
  localparam int DEF_NAME_BITS     = 32;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_BIND  = 2'd1;
  localparam logic [1:0] OP_FREE  = 2'd2;
  localparam logic [1:0] OP_QUERY = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_INVALID  = 3'd1;
  localparam logic [2:0] ST_NEGATIVE = 3'd2;
  localparam logic [2:0] ST_NOT_FREE = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

endpackage

>>> hdl/nra_if.sv
// ----------------------------------------------------------------------------
// nra_req_if / nra_rsp_if
// Valid/ready channels for requests and responses of the allocator.
// ----------------------------------------------------------------------------
interface nra_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic [31:0]        name;
  logic signed [31:0] count;
  logic               in_begin_end;
  modport source (output valid, opcode, name, count, in_begin_end, input ready);
  modport sink   (input valid, opcode, name, count, in_begin_end, output ready);
endinterface

interface nra_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] first_name;
  logic        in_use;
  logic [2:0]  status;
  modport source (output valid, first_name, in_use, status, input ready);
  modport sink   (input valid, first_name, in_use, status, output ready);
endinterface

>>> hdl/nra_table.sv
// ----------------------------------------------------------------------------
// nra_table
// Interval memory: one write port, one read port with registered data.
// Entry 0 reads as the full range until it is first written.
// ----------------------------------------------------------------------------
module nra_table
  import nra_pkg::*;
#(
  parameter int MAX_INTERVALS = DEF_MAX_INTERVALS,
  parameter int NAME_BITS     = DEF_NAME_BITS,
  localparam int AW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [AW-1:0]        raddr,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  logic [NAME_BITS-1:0] wstart,
  input  logic [NAME_BITS-1:0] wend,
  output logic [NAME_BITS-1:0] rstart,
  output logic [NAME_BITS-1:0] rend
);

  logic [NAME_BITS-1:0] mem_start [MAX_INTERVALS];
  logic [NAME_BITS-1:0] mem_end   [MAX_INTERVALS];
  logic [NAME_BITS-1:0] rd_start;
  logic [NAME_BITS-1:0] rd_end;
  logic                 init0;
  logic                 rd_init;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_start[waddr] <= wstart;
      mem_end[waddr]   <= wend;
    end
    rd_start <= mem_start[raddr];
    rd_end   <= mem_end[raddr];
  end

  // entry 0 holds the reset interval until its first write
  always_ff @(posedge clk) begin
    if (rst) begin
      init0   <= 1'b1;
      rd_init <= 1'b0;
    end else begin
      rd_init <= init0 && (raddr == '0);
      if (we && waddr == '0) begin
        init0 <= 1'b0;
      end
    end
  end

  assign rstart = rd_init ? NAME_BITS'(1) : rd_start;
  assign rend   = rd_init ? {NAME_BITS{1'b1}} : rd_end;

endmodule

>>> hdl/name_range_allocator.sv
// ----------------------------------------------------------------------------
// name_range_allocator
// First-fit allocator of contiguous names over a sorted table of free
// intervals, with bind, free (merging) and query operations.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one operation per item (opcode, name, count, in_begin_end);
//   rsp returns exactly one item per request (first_name, in_use, status).
//   Both are valid/ready channels; an item moves when valid and ready are high.
// Timing:
//   The interval table sits in a single-port-write, registered-read memory.
//   An operation scans the table, with a read state and an evaluate state per
//   interval visited, then moves trailing intervals, with a read and a write state
//   each, when an entry is removed or inserted, then writes up to two new entries.
//   Requests rejected at decode and trivial operations skip the scan entirely.
//   One operation is in flight at a time; the next request is taken once the
//   previous result sits in the output register.
// Reset:
//   rst (synchronous) leaves one free interval [1, 2^NAME_BITS-1]; no clearing
//   pass is needed.
// Stall:
//   A result waiting on rsp.ready holds in the output register; a following
//   request may be accepted and worked on, but completes only once rsp drains.
// ----------------------------------------------------------------------------
module name_range_allocator
  import nra_pkg::*;
#(
  parameter int MAX_INTERVALS = DEF_MAX_INTERVALS,
  parameter int NAME_BITS     = DEF_NAME_BITS
) (
  input logic      clk,
  input logic      rst,
  nra_req_if.sink  req,
  nra_rsp_if.source rsp
);

  localparam int W  = NAME_BITS;
  localparam int AW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
  localparam int CW = $clog2(MAX_INTERVALS + 1);
  localparam logic [W-1:0] NAME_MAX = {W{1'b1}};

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_EV, S_PLAN, S_MRD, S_MWR, S_NEW, S_DONE
  } state_t;

  state_t        state;
  logic [1:0]    op;
  logic [W-1:0]  nm;
  logic [30:0]   cnt;
  logic [W-1:0]  lo, hi;
  logic [CW-1:0] k, tab_cnt, idx_i, idx_j, src, dst, src_stop;
  logic [1:0]    nn;
  logic          asc, ifound, second;
  logic [W-1:0]  ms, me, new_s0, new_e0, new_s1, new_e1;
  logic [W-1:0]  res_first;
  logic          res_use;
  logic [2:0]    res_status;

  logic [AW-1:0] raddr, waddr;
  logic          we;
  logic [W-1:0]  wstart, wend, rs, re;

  // request decode
  logic [W-1:0]  in_nm;
  logic [32:0]   in_hi33;
  logic [W-1:0]  in_hi, in_lo;
  assign in_nm   = req.name[W-1:0];
  assign in_hi33 = 33'(in_nm) + 33'(req.count[30:0]) - 33'd1;
  assign in_hi   = (in_hi33 > 33'(NAME_MAX)) ? NAME_MAX : in_hi33[W-1:0];
  assign in_lo   = (in_nm == '0) ? W'(1) : in_nm;

  // scan comparisons on the entry just read
  logic          fits, exact, holds, reach_lo, past_hi;
  logic [W:0]    e_p1, hi_p1;
  assign fits     = 33'(re - rs) >= (33'(cnt) - 33'd1);
  assign exact    = 33'(re - rs) == (33'(cnt) - 33'd1);
  assign holds    = (rs <= nm) && (nm <= re);
  assign e_p1     = (W+1)'(re) + (W+1)'(1);
  assign hi_p1    = (W+1)'(hi) + (W+1)'(1);
  assign reach_lo = e_p1 >= (W+1)'(lo);
  assign past_hi  = (W+1)'(rs) > hi_p1;

  // edit planning
  logic [CW:0]   dst0, keep_cnt;
  assign dst0     = (CW+1)'(idx_i) + (CW+1)'(nn);
  assign keep_cnt = dst0 + (CW+1)'(tab_cnt) - (CW+1)'(idx_j);

  logic [CW:0]   fr_need;
  assign fr_need = (CW+1)'(ifound ? idx_i : k) + (CW+1)'(1) + (CW+1)'(tab_cnt)
                   - (CW+1)'(k);

  assign req.ready = (state == S_IDLE);

  always_comb begin
    raddr  = (state == S_MRD) ? src[AW-1:0] : k[AW-1:0];
    we     = 1'b0;
    waddr  = dst[AW-1:0];
    wstart = rs;
    wend   = re;
    if (state == S_MWR) begin
      we = 1'b1;
    end else if (state == S_NEW) begin
      we     = (nn != 2'd0);
      waddr  = second ? AW'(idx_i + CW'(1)) : idx_i[AW-1:0];
      wstart = second ? new_s1 : new_s0;
      wend   = second ? new_e1 : new_e0;
    end
  end

  nra_table #(.MAX_INTERVALS(MAX_INTERVALS), .NAME_BITS(NAME_BITS)) u_table (
    .clk(clk), .rst(rst), .raddr(raddr), .we(we), .waddr(waddr),
    .wstart(wstart), .wend(wend), .rstart(rs), .rend(re)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      tab_cnt   <= CW'(1);
      rsp.valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            op         <= req.opcode;
            nm         <= in_nm;
            cnt        <= req.count[30:0];
            lo         <= in_lo;
            hi         <= in_hi;
            ms         <= in_lo;
            me         <= in_hi;
            k          <= '0;
            ifound     <= 1'b0;
            second     <= 1'b0;
            res_first  <= '0;
            res_use    <= 1'b0;
            res_status <= ST_OK;
            state      <= S_RD;
            if (req.in_begin_end) begin
              res_status <= ST_INVALID;
              state      <= S_DONE;
            end else if ((req.opcode == OP_ALLOC || req.opcode == OP_FREE)
                         && req.count[31]) begin
              res_status <= ST_NEGATIVE;
              state      <= S_DONE;
            end else if ((req.opcode == OP_ALLOC || req.opcode == OP_FREE)
                         && req.count[30:0] == '0) begin
              state <= S_DONE;
            end else if (req.opcode == OP_FREE && in_lo > in_hi) begin
              state <= S_DONE;
            end
          end
        end
        S_RD: begin
          if (k == tab_cnt) begin
            // end of table
            state <= S_DONE;
            case (op)
              OP_BIND:  res_status <= ST_NOT_FREE;
              OP_QUERY: res_use    <= 1'b1;
              OP_FREE: begin
                if (!ifound) begin
                  idx_i <= k;
                end
                idx_j <= k;
                state <= S_PLAN;
                if ((CW+1)'(ifound ? idx_i : k) + (CW+1)'(1) > (CW+1)'(MAX_INTERVALS)) begin
                  res_status <= ST_FULL;
                  state      <= S_DONE;
                end
              end
              default: ;
            endcase
          end else begin
            state <= S_EV;
          end
        end
        S_EV: begin
          k     <= k + CW'(1);
          state <= S_RD;
          idx_i <= k;
          idx_j <= k + CW'(1);
          case (op)
            OP_ALLOC: begin
              if (fits) begin
                res_first <= rs;
                nn        <= exact ? 2'd0 : 2'd1;
                new_s0    <= rs + W'(cnt);
                new_e0    <= re;
                state     <= S_PLAN;
              end
            end
            OP_QUERY: begin
              if (holds) begin
                state <= S_DONE;
              end
            end
            OP_BIND: begin
              if (holds) begin
                state <= S_PLAN;
                if (rs == nm && re == nm) begin
                  nn <= 2'd0;
                end else if (rs == nm) begin
                  nn     <= 2'd1;
                  new_s0 <= nm + W'(1);
                  new_e0 <= re;
                end else if (re == nm) begin
                  nn     <= 2'd1;
                  new_s0 <= rs;
                  new_e0 <= nm - W'(1);
                end else if (tab_cnt == CW'(MAX_INTERVALS)) begin
                  res_status <= ST_FULL;
                  state      <= S_DONE;
                end else begin
                  nn     <= 2'd2;
                  new_s0 <= rs;
                  new_e0 <= nm - W'(1);
                  new_s1 <= nm + W'(1);
                  new_e1 <= re;
                end
              end
            end
            default: begin
              // free: find the first touching interval, then the first past hi+1
              if (!ifound) begin
                idx_i <= k;
              end else begin
                idx_i <= idx_i;
              end
              if (ifound || reach_lo) begin
                ifound <= 1'b1;
                if (past_hi) begin
                  idx_j <= k;
                  k     <= k;
                  state <= S_PLAN;
                  if (fr_need > (CW+1)'(MAX_INTERVALS)) begin
                    res_status <= ST_FULL;
                    state      <= S_DONE;
                  end
                end else begin
                  if (!ifound && rs < lo) begin
                    ms <= rs;
                  end
                  if (re > hi) begin
                    me <= re;
                  end
                end
              end
            end
          endcase
        end
        S_PLAN: begin
          if (op == OP_FREE) begin
            nn     <= 2'd1;
            new_s0 <= ms;
            new_e0 <= me;
          end
          tab_cnt <= CW'(keep_cnt);
          state   <= S_MRD;
          if (op == OP_FREE) begin
            if (dst0 + (CW+1)'(1) - (CW+1)'(nn) < (CW+1)'(idx_j)) begin
              asc <= 1'b1;
            end else begin
              asc <= 1'b0;
            end
          end else begin
            asc <= dst0 < (CW+1)'(idx_j);
          end
          if (idx_j == tab_cnt
              || (op == OP_FREE ? (idx_i + CW'(1)) : CW'(dst0)) == idx_j) begin
            state <= S_NEW;
          end else if ((op == OP_FREE ? (idx_i + CW'(1)) : CW'(dst0)) < idx_j) begin
            src      <= idx_j;
            dst      <= (op == OP_FREE) ? idx_i + CW'(1) : CW'(dst0);
            src_stop <= tab_cnt - CW'(1);
          end else begin
            src      <= tab_cnt - CW'(1);
            dst      <= tab_cnt - CW'(1) + ((op == OP_FREE) ? idx_i + CW'(1) : CW'(dst0))
                        - idx_j;
            src_stop <= idx_j;
          end
          if (op == OP_FREE) begin
            tab_cnt <= idx_i + CW'(1) + tab_cnt - idx_j;
          end
        end
        S_MRD: state <= S_MWR;
        S_MWR: begin
          state <= S_MRD;
          if (src == src_stop) begin
            state <= S_NEW;
          end else if (asc) begin
            src <= src + CW'(1);
            dst <= dst + CW'(1);
          end else begin
            src <= src - CW'(1);
            dst <= dst - CW'(1);
          end
        end
        S_NEW: begin
          // the table is written while in this state, one new entry per pass, when entries are due
          if (nn == 2'd2 && !second) begin
            second <= 1'b1;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid      <= 1'b1;
            rsp.first_name <= 32'(res_first);
            rsp.in_use     <= res_use;
            rsp.status     <= res_status;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> hdl/nra_checker.sv
// ----------------------------------------------------------------------------
// nra_checker
// Port-level checks of the allocator's responses, bound to the top level.
// ----------------------------------------------------------------------------
module nra_checker
  import nra_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [31:0] rsp_first_name,
  input logic        rsp_in_use,
  input logic [2:0]  rsp_status
);

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_status <= ST_FULL))
    else $error("status code out of range");

  a_in_use_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_in_use) |-> (rsp_status == ST_OK && rsp_first_name == '0))
    else $error("in_use set on a failed or non-query result");

  a_first_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_first_name != '0) |-> (rsp_status == ST_OK && !rsp_in_use))
    else $error("first_name set on a failed result");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_first_name)
                                   && $stable(rsp_status)))
    else $error("stalled result changed");

endmodule

bind name_range_allocator nra_checker u_nra_checker (
  .clk(clk), .rst(rst), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
  .rsp_first_name(rsp.first_name), .rsp_in_use(rsp.in_use), .rsp_status(rsp.status)
);
